[rtl/core/sgeos_pkg.sv]
// Shared widths, codes and fixed-point helpers for the stiffened-gas EOS pipeline.
package sgeos_pkg;

   localparam int DATA_W   = 48;
   localparam int FRAC_W   = 24;
   localparam int GAMMA_W  = 31;
   localparam int STIFF_W  = 47;
   localparam int CSR_IDX_W = 1;
   localparam int STATUS_W = 2;

   localparam int DIV_N_W  = 2 * DATA_W;
   localparam int DIV_D_W  = DATA_W + 1;
   localparam int DIV_Q_W  = DATA_W;

   localparam int SQRT_IN_W   = DATA_W + FRAC_W;
   localparam int SQRT_ROOT_W = SQRT_IN_W / 2;
   localparam int SQRT_REM_W  = SQRT_ROOT_W + 2;

   localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(23488102);
   localparam logic [31:0]        ONE_Q       = 32'(1) << FRAC_W;

   localparam logic [63:0] LIM_POS = (64'd1 << (DATA_W - 1)) - 64'd1;
   localparam logic [63:0] LIM_NEG = 64'd1 << (DATA_W - 1);
   localparam logic [DATA_W-1:0] MAX_POS = LIM_POS[DATA_W-1:0];
   localparam logic [DATA_W-1:0] MIN_NEG = LIM_NEG[DATA_W-1:0];

   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_STIFF = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_RHO  = 2'd1,
      ST_ROOT = 2'd2
   } status_type;

   // Two's complement add, clamped to the signed data range.
   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         sat_add = s[DATA_W] ? MIN_NEG : MAX_POS;
      end else begin
         sat_add = s[DATA_W-1:0];
      end
   endfunction

   function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] a);
      mag = a[DATA_W-1] ? (~a + DATA_W'(1)) : a;
   endfunction

   // Clamp a magnitude to the range allowed for its sign, then apply the sign.
   function automatic logic [DATA_W-1:0] finish(input logic [63:0] m, input logic neg);
      logic [63:0]       lim;
      logic [DATA_W-1:0] v;
      lim = neg ? LIM_NEG : LIM_POS;
      v = (m > lim) ? lim[DATA_W-1:0] : m[DATA_W-1:0];
      finish = neg ? (~v + DATA_W'(1)) : v;
   endfunction

endpackage

[rtl/core/sgeos_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module sgeos_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [sgeos_pkg::DIV_N_W-1:0] num,
   input  logic [sgeos_pkg::DIV_D_W-1:0] den,
   output logic                          out_valid,
   output logic [sgeos_pkg::DIV_Q_W-1:0] quo,
   output logic                          sat
);
   import sgeos_pkg::*;

   typedef struct packed {
      logic [DIV_D_W-1:0] rem;
      logic [DIV_Q_W-1:0] nlow;
      logic [DIV_Q_W-1:0] quo;
      logic [DIV_D_W-1:0] den;
      logic               sat;
   } div_stage_type;

   function automatic div_stage_type div_step(input div_stage_type s);
      div_stage_type      r;
      logic [DIV_D_W:0]   t;
      logic [DIV_D_W:0]   diff;
      logic               ge;
      r = s;
      t = {s.rem, s.nlow[DIV_Q_W-1]};
      diff = t - {1'b0, s.den};
      ge = (t >= {1'b0, s.den});
      r.rem = ge ? diff[DIV_D_W-1:0] : t[DIV_D_W-1:0];
      r.nlow = {s.nlow[DIV_Q_W-2:0], 1'b0};
      r.quo = {s.quo[DIV_Q_W-2:0], ge};
      div_step = r;
   endfunction

   div_stage_type      stage_ff [DIV_Q_W];
   div_stage_type      stage_in [DIV_Q_W];
   div_stage_type      init;
   logic [DIV_Q_W-1:0] valid_ff;

   always_comb begin
      init.rem = {1'b0, num[DIV_N_W-1:DIV_Q_W]};
      init.nlow = num[DIV_Q_W-1:0];
      init.quo = '0;
      init.den = den;
      init.sat = ({1'b0, num[DIV_N_W-1:DIV_Q_W]} >= den);
      stage_in[0] = div_step(init);
      for (int k = 1; k < DIV_Q_W; k++) begin
         stage_in[k] = div_step(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[DIV_Q_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_Q_W; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_Q_W-1];
   assign quo       = stage_ff[DIV_Q_W-1].quo;
   assign sat       = stage_ff[DIV_Q_W-1].sat;

   a_rem_first: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] && !stage_ff[0].sat |-> stage_ff[0].rem < stage_ff[0].den)
      else $error("divider remainder out of range after first step");
   a_rem_last: assert property (@(posedge clock) disable iff (reset)
      out_valid && !sat |-> stage_ff[DIV_Q_W-1].rem < stage_ff[DIV_Q_W-1].den)
      else $error("divider remainder out of range at output");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("divider valid bits moved while held");

endmodule

[rtl/core/sgeos_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module sgeos_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [sgeos_pkg::SQRT_IN_W-1:0]   rad,
   output logic                              out_valid,
   output logic [sgeos_pkg::SQRT_ROOT_W-1:0] root
);
   import sgeos_pkg::*;

   typedef struct packed {
      logic [SQRT_REM_W-1:0]  rem;
      logic [SQRT_ROOT_W-1:0] root;
      logic [SQRT_IN_W-1:0]   vrest;
   } sqrt_stage_type;

   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s);
      sqrt_stage_type      r;
      logic [SQRT_REM_W+1:0] t;
      logic [SQRT_REM_W+1:0] trial;
      logic [SQRT_REM_W+1:0] diff;
      logic                ge;
      r = s;
      t = {s.rem, s.vrest[SQRT_IN_W-1:SQRT_IN_W-2]};
      trial = {2'b00, s.root, 2'b01};
      diff = t - trial;
      ge = (t >= trial);
      r.rem = ge ? diff[SQRT_REM_W-1:0] : t[SQRT_REM_W-1:0];
      r.root = {s.root[SQRT_ROOT_W-2:0], ge};
      r.vrest = {s.vrest[SQRT_IN_W-3:0], 2'b00};
      sqrt_step = r;
   endfunction

   sqrt_stage_type         stage_ff [SQRT_ROOT_W];
   sqrt_stage_type         stage_in [SQRT_ROOT_W];
   sqrt_stage_type         init;
   logic [SQRT_ROOT_W-1:0] valid_ff;

   always_comb begin
      init.rem = '0;
      init.root = '0;
      init.vrest = rad;
      stage_in[0] = sqrt_step(init);
      for (int k = 1; k < SQRT_ROOT_W; k++) begin
         stage_in[k] = sqrt_step(stage_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[SQRT_ROOT_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < SQRT_ROOT_W; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_ROOT_W-1];
   assign root      = stage_ff[SQRT_ROOT_W-1].root;

   a_first_bit: assert property (@(posedge clock) disable iff (reset)
      valid_ff[0] |-> stage_ff[0].root[SQRT_ROOT_W-1:1] == '0)
      else $error("root has stray bits after first step");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> {1'b0, stage_ff[SQRT_ROOT_W-1].rem} <= {2'b00, root, 1'b0})
      else $error("root is not the floor square root");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("root valid bits moved while held");

endmodule

[rtl/core/stiffened_gas_eos_eval.sv]
// Stiffened-gas equation of state: pressure, enthalpy and sound speed per fluid cell.
//
// Usage:
//   The req_ channel carries one cell per item (density, three momentum components,
//   total energy, signed Q24.24). The rsp_ channel returns one item per cell with
//   pressure, specific enthalpy, sound speed and a status code, in input order.
//   Both channels move an item on a rising edge with valid high and stall low.
//   Throughput: one item per cycle unless rsp_stall holds a waiting result.
//   The path is a fixed pipeline: input capture, squares, a 48-stage divider for
//   kinetic energy, seven pressure stages, two 48-stage dividers side by side for
//   enthalpy and the root argument, and a 36-stage square root; each divider/root
//   stage resolves one bit.
//   Stall: when rsp_stall holds a waiting result, every stage holds and req_stall
//   rises; empty stages still count as slots, so bubbles are not squeezed out.
//   Reset: valid bits clear, gamma returns to 1.4 and stiffness to zero.
//   The csr_ port writes gamma (index 0) and stiffness (index 1); write only idle.
//   Status: density not positive zeroes all results; a negative root argument
//   zeroes the sound speed only.
module stiffened_gas_eos_eval (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sgeos_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sgeos_pkg::STIFF_W-1:0]       csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sgeos_pkg::DATA_W-1:0] req_density,
   input  logic signed [sgeos_pkg::DATA_W-1:0] req_momentum_x_in,
   input  logic signed [sgeos_pkg::DATA_W-1:0] req_momentum_y_in,
   input  logic signed [sgeos_pkg::DATA_W-1:0] req_momentum_z_in,
   input  logic signed [sgeos_pkg::DATA_W-1:0] req_total_energy,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sgeos_pkg::DATA_W-1:0] rsp_pressure_out,
   output logic signed [sgeos_pkg::DATA_W-1:0] rsp_enthalpy_out,
   output logic [sgeos_pkg::DATA_W-2:0]        rsp_sound_speed,
   output logic [sgeos_pkg::STATUS_W-1:0]      rsp_status
);
   import sgeos_pkg::*;

   localparam int W = DATA_W;
   localparam int H = FRAC_W;

   typedef struct packed {
      logic [W-1:0]        rho;
      logic [W-1:0]        e;
      logic [2:0][W-1:0]   mom;
   } st0_type;

   typedef struct packed {
      logic [W-1:0]        rho;
      logic [W-1:0]        e;
      logic [2:0][W-1:0]   hh;
      logic [2:0][W-1:0]   hl;
      logic [2:0][W-1:0]   ll;
      logic [GAMMA_W+H-1:0] gb_lo;
      logic [GAMMA_W+STIFF_W-H-1:0] gb_hi;
   } st1_type;

   typedef struct packed {
      logic [W-1:0]         rho;
      logic [W-1:0]         e;
      logic [2:0][2*W-1:0]  sq;
      logic [W-1:0]         gb;
   } st2_type;

   typedef struct packed {
      logic [W-1:0]   rho;
      logic [W-1:0]   e;
      logic [2*W-1:0] sumsq;
      logic [W-1:0]   gb;
   } st3_type;

   typedef struct packed {
      logic [W-1:0] rho;
      logic [W-1:0] e;
      logic [W-1:0] gb;
   } sa_type;

   typedef struct packed {
      logic [W-1:0] rho;
      logic [W-1:0] e;
      logic [W-1:0] gb;
      logic [W-1:0] inner;
      logic [31:0]  gm1;
      logic         rho_pos;
   } t1_type;

   typedef struct packed {
      logic [W-1:0]         rho;
      logic [W-1:0]         e;
      logic [W-1:0]         gb;
      logic                 rho_pos;
      logic [GAMMA_W+H-1:0] pl;
      logic [GAMMA_W+H-1:0] ph;
      logic                 neg;
   } t2_type;

   typedef struct packed {
      logic [W-1:0] rho;
      logic [W-1:0] e;
      logic [W-1:0] gb;
      logic         rho_pos;
      logic [W-1:0] term;
   } t3_type;

   typedef struct packed {
      logic [W-1:0] rho;
      logic [W-1:0] e;
      logic         rho_pos;
      logic [W-1:0] p;
   } t4_type;

   typedef struct packed {
      logic [W-1:0] rho;
      logic         rho_pos;
      logic [W-1:0] p;
      logic [W-1:0] s1;
      logic [W-1:0] s2;
   } t5_type;

   typedef struct packed {
      logic [W-1:0]         rho;
      logic                 rho_pos;
      logic [W-1:0]         p;
      logic [W-1:0]         s1;
      logic [GAMMA_W+H-1:0] pl;
      logic [GAMMA_W+H-1:0] ph;
      logic                 neg;
   } t6_type;

   typedef struct packed {
      logic [W-1:0] rho;
      logic         rho_pos;
      logic [W-1:0] p;
      logic [W-1:0] s1;
      logic [W-1:0] garg;
   } t7_type;

   typedef struct packed {
      logic [W-1:0] p;
      logic         s1_neg;
      logic         g_neg;
      logic         rho_pos;
   } sb_type;

   typedef struct packed {
      logic [W-1:0] p;
      logic [W-1:0] h;
      logic [W-1:0] arg;
      status_type   status;
   } u0_type;

   typedef struct packed {
      logic [W-1:0] p;
      logic [W-1:0] h;
      status_type   status;
   } sc_type;

   typedef struct packed {
      logic [W-1:0] p;
      logic [W-1:0] h;
      logic [W-2:0] c;
      status_type   status;
   } out_type;

   // configuration
   logic [GAMMA_W-1:0] gamma_ff;
   logic [STIFF_W-1:0] stiff_ff;

   // pipeline registers
   st0_type st0_ff, st0_in;
   st1_type st1_ff, st1_in;
   st2_type st2_ff, st2_in;
   st3_type st3_ff, st3_in;
   t1_type  t1_ff, t1_in;
   t2_type  t2_ff, t2_in;
   t3_type  t3_ff, t3_in;
   t4_type  t4_ff, t4_in;
   t5_type  t5_ff, t5_in;
   t6_type  t6_ff, t6_in;
   t7_type  t7_ff, t7_in;
   u0_type  u0_ff, u0_in;
   out_type out_ff, out_in;
   sa_type  sa_ff [DIV_Q_W];
   sb_type  sb_ff [DIV_Q_W];
   sc_type  sc_ff [SQRT_ROOT_W];

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic t1_v_ff, t2_v_ff, t3_v_ff, t4_v_ff, t5_v_ff, t6_v_ff, t7_v_ff;
   logic u0_v_ff, rsp_valid_ff;

   logic adv;

   // divider and root hookups
   logic                   diva_valid, divb_valid, divc_valid, sq_valid;
   logic [DIV_Q_W-1:0]     diva_q, divb_q, divc_q;
   logic                   diva_sat, divb_sat, divc_sat;
   logic [DIV_N_W-1:0]     divb_num, divc_num;
   logic [SQRT_ROOT_W-1:0] sq_root;

   // Advance every stage unless a finished result is waiting on the receiver.
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= GAMMA_RESET;
         stiff_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GAMMA: gamma_ff <= csr_wdata[GAMMA_W-1:0];
            CSR_STIFF: stiff_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front: capture, square partial products, g*B, sum of squares.
   always_comb begin
      logic [W-1:0]  am;
      logic [55:0]   gbs;
      st0_in.rho = req_density;
      st0_in.e = req_total_energy;
      st0_in.mom[0] = req_momentum_x_in;
      st0_in.mom[1] = req_momentum_y_in;
      st0_in.mom[2] = req_momentum_z_in;

      st1_in.rho = st0_ff.rho;
      st1_in.e = st0_ff.e;
      for (int k = 0; k < 3; k++) begin
         am = mag(st0_ff.mom[k]);
         st1_in.hh[k] = W'(am[W-1:H]) * W'(am[W-1:H]);
         st1_in.hl[k] = W'(am[W-1:H]) * W'(am[H-1:0]);
         st1_in.ll[k] = W'(am[H-1:0]) * W'(am[H-1:0]);
      end
      st1_in.gb_lo = (GAMMA_W+H)'(gamma_ff) * (GAMMA_W+H)'(stiff_ff[H-1:0]);
      st1_in.gb_hi = (GAMMA_W+STIFF_W-H)'(gamma_ff)
                   * (GAMMA_W+STIFF_W-H)'(stiff_ff[STIFF_W-1:H]);

      st2_in.rho = st1_ff.rho;
      st2_in.e = st1_ff.e;
      for (int k = 0; k < 3; k++) begin
         st2_in.sq[k] = ((2*W)'(st1_ff.hh[k]) << W) + ((2*W)'(st1_ff.hl[k]) << (H + 1))
                      + (2*W)'(st1_ff.ll[k]);
      end
      gbs = 56'(st1_ff.gb_hi) + 56'(st1_ff.gb_lo >> H);
      st2_in.gb = finish(64'(gbs), 1'b0);

      st3_in.rho = st2_ff.rho;
      st3_in.e = st2_ff.e;
      st3_in.gb = st2_ff.gb;
      st3_in.sumsq = st2_ff.sq[0] + st2_ff.sq[1] + st2_ff.sq[2];
   end

   // Kinetic energy = sum of squares / (2 rho).
   sgeos_div u_div_ke (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v3_ff),
      .num       (st3_ff.sumsq),
      .den       ({st3_ff.rho, 1'b0}),
      .out_valid (diva_valid),
      .quo       (diva_q),
      .sat       (diva_sat)
   );

   // Pressure chain.
   always_comb begin
      logic [W-1:0]         ke;
      logic [W-1:0]         im;
      logic [31:0]          gmag;
      logic [55:0]          ts;
      logic [W-1:0]         s2m;
      ke = finish(diva_sat ? '1 : 64'(diva_q), 1'b0);

      t1_in.rho = sa_ff[DIV_Q_W-1].rho;
      t1_in.e = sa_ff[DIV_Q_W-1].e;
      t1_in.gb = sa_ff[DIV_Q_W-1].gb;
      t1_in.inner = sat_add(sa_ff[DIV_Q_W-1].e, ~ke + W'(1));
      t1_in.gm1 = {1'b0, gamma_ff} - ONE_Q;
      t1_in.rho_pos = !sa_ff[DIV_Q_W-1].rho[W-1] && (sa_ff[DIV_Q_W-1].rho != '0);

      im = mag(t1_ff.inner);
      gmag = t1_ff.gm1[31] ? (~t1_ff.gm1 + 32'd1) : t1_ff.gm1;
      t2_in.rho = t1_ff.rho;
      t2_in.e = t1_ff.e;
      t2_in.gb = t1_ff.gb;
      t2_in.rho_pos = t1_ff.rho_pos;
      t2_in.neg = t1_ff.gm1[31] ^ t1_ff.inner[W-1];
      t2_in.pl = (GAMMA_W+H)'(gmag[GAMMA_W-1:0]) * (GAMMA_W+H)'(im[H-1:0]);
      t2_in.ph = (GAMMA_W+H)'(gmag[GAMMA_W-1:0]) * (GAMMA_W+H)'(im[W-1:H]);

      ts = 56'(t2_ff.ph) + 56'(t2_ff.pl >> H);
      t3_in.rho = t2_ff.rho;
      t3_in.e = t2_ff.e;
      t3_in.gb = t2_ff.gb;
      t3_in.rho_pos = t2_ff.rho_pos;
      t3_in.term = finish(64'(ts), t2_ff.neg);

      t4_in.rho = t3_ff.rho;
      t4_in.e = t3_ff.e;
      t4_in.rho_pos = t3_ff.rho_pos;
      t4_in.p = sat_add(~t3_ff.gb + W'(1), t3_ff.term);

      t5_in.rho = t4_ff.rho;
      t5_in.rho_pos = t4_ff.rho_pos;
      t5_in.p = t4_ff.p;
      t5_in.s1 = sat_add(t4_ff.e, t4_ff.p);
      t5_in.s2 = sat_add(t4_ff.p, {1'b0, stiff_ff});

      s2m = mag(t5_ff.s2);
      t6_in.rho = t5_ff.rho;
      t6_in.rho_pos = t5_ff.rho_pos;
      t6_in.p = t5_ff.p;
      t6_in.s1 = t5_ff.s1;
      t6_in.neg = t5_ff.s2[W-1];
      t6_in.pl = (GAMMA_W+H)'(gamma_ff) * (GAMMA_W+H)'(s2m[H-1:0]);
      t6_in.ph = (GAMMA_W+H)'(gamma_ff) * (GAMMA_W+H)'(s2m[W-1:H]);

      ts = 56'(t6_ff.ph) + 56'(t6_ff.pl >> H);
      t7_in.rho = t6_ff.rho;
      t7_in.rho_pos = t6_ff.rho_pos;
      t7_in.p = t6_ff.p;
      t7_in.s1 = t6_ff.s1;
      t7_in.garg = finish(64'(ts), t6_ff.neg);
   end

   assign divb_num = {H'(0), mag(t7_ff.s1), H'(0)};
   assign divc_num = {H'(0), mag(t7_ff.garg), H'(0)};

   // Enthalpy = (E + p) / rho.
   sgeos_div u_div_h (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (t7_v_ff),
      .num       (divb_num),
      .den       ({1'b0, t7_ff.rho}),
      .out_valid (divb_valid),
      .quo       (divb_q),
      .sat       (divb_sat)
   );

   // Root argument = g (p + B) / rho.
   sgeos_div u_div_arg (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (t7_v_ff),
      .num       (divc_num),
      .den       ({1'b0, t7_ff.rho}),
      .out_valid (divc_valid),
      .quo       (divc_q),
      .sat       (divc_sat)
   );

   // Sign the quotients, pick status, and zero results for bad density.
   always_comb begin
      sb_type       sb;
      logic [W-1:0] h;
      logic [W-1:0] arg;
      sb = sb_ff[DIV_Q_W-1];
      h = finish(divb_sat ? '1 : 64'(divb_q), sb.s1_neg);
      arg = finish(divc_sat ? '1 : 64'(divc_q), sb.g_neg);
      u0_in.arg = arg;
      if (!sb.rho_pos) begin
         u0_in.p = '0;
         u0_in.h = '0;
         u0_in.status = ST_RHO;
      end else begin
         u0_in.p = sb.p;
         u0_in.h = h;
         u0_in.status = arg[W-1] ? ST_ROOT : ST_OK;
      end
   end

   sgeos_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (u0_v_ff),
      .rad       ({1'b0, u0_ff.arg[W-2:0], H'(0)}),
      .out_valid (sq_valid),
      .root      (sq_root)
   );

   always_comb begin
      out_in.p = sc_ff[SQRT_ROOT_W-1].p;
      out_in.h = sc_ff[SQRT_ROOT_W-1].h;
      out_in.status = sc_ff[SQRT_ROOT_W-1].status;
      out_in.c = (sc_ff[SQRT_ROOT_W-1].status == ST_OK) ? (W-1)'(sq_root) : '0;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         t1_v_ff <= 1'b0;
         t2_v_ff <= 1'b0;
         t3_v_ff <= 1'b0;
         t4_v_ff <= 1'b0;
         t5_v_ff <= 1'b0;
         t6_v_ff <= 1'b0;
         t7_v_ff <= 1'b0;
         u0_v_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         t1_v_ff <= diva_valid;
         t2_v_ff <= t1_v_ff;
         t3_v_ff <= t2_v_ff;
         t4_v_ff <= t3_v_ff;
         t5_v_ff <= t4_v_ff;
         t6_v_ff <= t5_v_ff;
         t7_v_ff <= t6_v_ff;
         u0_v_ff <= divb_valid;
         rsp_valid_ff <= sq_valid;
      end
   end

   // payload, including side lines that ride alongside the dividers and root
   always_ff @(posedge clock) begin
      if (adv) begin
         st0_ff <= st0_in;
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         t1_ff <= t1_in;
         t2_ff <= t2_in;
         t3_ff <= t3_in;
         t4_ff <= t4_in;
         t5_ff <= t5_in;
         t6_ff <= t6_in;
         t7_ff <= t7_in;
         u0_ff <= u0_in;
         out_ff <= out_in;
         sa_ff[0] <= '{rho: st3_ff.rho, e: st3_ff.e, gb: st3_ff.gb};
         sb_ff[0] <= '{p: t7_ff.p, s1_neg: t7_ff.s1[W-1], g_neg: t7_ff.garg[W-1],
                       rho_pos: t7_ff.rho_pos};
         sc_ff[0] <= '{p: u0_ff.p, h: u0_ff.h, status: u0_ff.status};
         for (int k = 1; k < DIV_Q_W; k++) begin
            sa_ff[k] <= sa_ff[k-1];
            sb_ff[k] <= sb_ff[k-1];
         end
         for (int k = 1; k < SQRT_ROOT_W; k++) begin
            sc_ff[k] <= sc_ff[k-1];
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pressure_out = out_ff.p;
   assign rsp_enthalpy_out = out_ff.h;
   assign rsp_sound_speed  = out_ff.c;
   assign rsp_status       = out_ff.status;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      divb_valid == divc_valid)
      else $error("enthalpy and root-argument dividers out of step");
   a_root_arg_pos: assert property (@(posedge clock) disable iff (reset)
      u0_v_ff && u0_ff.status == ST_OK |-> !u0_ff.arg[W-1])
      else $error("negative argument sent to root with good status");
   a_bad_rho_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_ff.status == ST_RHO |->
         out_ff.p == '0 && out_ff.h == '0 && out_ff.c == '0)
      else $error("results not zeroed for bad density");
   a_bad_root_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_ff.status == ST_ROOT |-> out_ff.c == '0)
      else $error("sound speed not zeroed for negative root argument");

endmodule
